### rtl/alp_pkg.sv
// Shared constants, record layouts and saturating helpers of the lifetime profiler.
`timescale 1ns / 1ps
package alp_pkg;

  localparam int TABLE_BITS = 16;
  localparam int SITE_BITS  = 10;
  localparam int CLR_BITS   = (TABLE_BITS > SITE_BITS) ? TABLE_BITS : SITE_BITS;

  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;

  // Configuration register indexes.
  localparam logic [1:0] REG_SHORT = 2'd0;
  localparam logic [1:0] REG_MID   = 2'd1;
  localparam logic [1:0] REG_LONG  = 2'd2;

  localparam logic [39:0] SHORT_RESET = 40'd100;
  localparam logic [39:0] MID_RESET   = 40'd10000;
  localparam logic [39:0] LONG_RESET  = 40'd1000000;

  // Request codes.
  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_ALLOC   = 3'd0;
  localparam logic [2:0] ST_MATCH   = 3'd1;
  localparam logic [2:0] ST_UNMATCH = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;

  // One hash table slot. The home index is kept so that deletion needs no rehash.
  typedef struct packed {
    logic                  valid;
    logic [TABLE_BITS-1:0] home;
    logic [59:0]           addr;
    logic [39:0]           seq;
    logic [SITE_BITS-1:0]  site;
    logic [31:0]           size;
  } slot_word_t;

  // All counters of one allocation site.
  typedef struct packed {
    logic [39:0]       alloc_count;
    logic [47:0]       alloc_bytes;
    logic [39:0]       free_count;
    logic [47:0]       lifetime_sum;
    logic [3:0][39:0]  bucket;
    logic [47:0]       live_bytes;
  } site_word_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

  function automatic logic [39:0] sat_inc40(input logic [39:0] a);
    return (a == {40{1'b1}}) ? a : a + 40'd1;
  endfunction

endpackage

### rtl/alp_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module alp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/alp_hash.sv
// Fibonacci hash of a 60-bit address, built from three successive 32x32 products.
`timescale 1ns / 1ps
module alp_hash (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [59:0]                    addr,
  output logic                           done,
  output logic [alp_pkg::TABLE_BITS-1:0] home
);

  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_LL   = 3'd1;
  localparam logic [2:0] STEP_LH   = 3'd2;
  localparam logic [2:0] STEP_HL   = 3'd3;
  localparam logic [2:0] STEP_SUM  = 3'd4;

  logic [2:0]  step_r;
  logic [31:0] a0_r;
  logic [27:0] a1_r;
  logic [63:0] prod_r;
  logic [31:0] acc_r;
  logic        done_r;
  logic [31:0] mul_a, mul_b;

  // Only the low 64 bits of the product matter, so the high-by-high term drops out.
  always_comb begin
    mul_a = a0_r;
    mul_b = alp_pkg::GOLDEN[31:0];
    unique case (step_r)
      STEP_LH: mul_b = alp_pkg::GOLDEN[63:32];
      STEP_HL: mul_a = {4'd0, a1_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (step_r)
        STEP_IDLE: if (start) step_r <= STEP_LL;
        STEP_LL:   step_r <= STEP_LH;
        STEP_LH:   step_r <= STEP_HL;
        STEP_HL:   step_r <= STEP_SUM;
        STEP_SUM: begin
          step_r <= STEP_IDLE;
          done_r <= 1'b1;
        end
        default:   step_r <= STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step_r == STEP_IDLE && start) begin
      a0_r <= addr[31:0];
      a1_r <= addr[59:32];
    end
    prod_r <= mul_a * mul_b;
    if (step_r == STEP_LH) begin
      acc_r <= prod_r[63:32];
    end else if (step_r == STEP_HL || step_r == STEP_SUM) begin
      acc_r <= acc_r + prod_r[31:0];
    end
  end

  assign done = done_r;
  assign home = acc_r[31 -: alp_pkg::TABLE_BITS];

endmodule

### rtl/alloc_lifetime_profiler_unit.sv
// Top level of the allocation lifetime profiler: control sequencer, registers and memories.
`timescale 1ns / 1ps
// The block takes allocation-trace records on a command port. A record is transferred
// at a rising edge where start is high and busy is low; in_func selects an allocation,
// a free, or a read of one site's statistics. Exactly one result comes back per record,
// held on the out_ ports for a single cycle while out_valid is high. The receiver cannot
// stall: results must be captured in that cycle.
//
// Latency depends on the probe length in the hash table. An allocation walks P occupied
// slots before a free one; a free walks P slots to its match and then the run D of
// occupied slots after the removed entry that the backward-shift deletion walks. A free
// that finds no match returns once its probe ends, and a statistics read needs no probe.
// The slot memory's single read port sets the pace: one slot is visited per cycle, and
// the hash itself uses one shared 32x32 multiplier for its three products. A new record
// is taken in the cycle its predecessor's result is shown.
//
// After reset, busy stays high while a clearing pass zeroes every slot and site counter.
// Configuration writes on the APB port are taken throughout and should be made only
// while no record is in flight.
module alloc_lifetime_profiler_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [59:0]                   in_address,
  input  logic [9:0]                    in_site,
  input  logic [47:0]                   in_size,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [9:0]                    out_site_out,
  output logic [39:0]                   out_lifetime,
  output logic [39:0]                   out_alloc_count,
  output logic [47:0]                   out_alloc_bytes,
  output logic [39:0]                   out_free_count,
  output logic [47:0]                   out_lifetime_sum,
  output logic [39:0]                   out_short_count,
  output logic [39:0]                   out_mid_count,
  output logic [39:0]                   out_long_count,
  output logic [39:0]                   out_longest_count,
  output logic [47:0]                   out_live_bytes,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  localparam int TB = alp_pkg::TABLE_BITS;
  localparam int SB = alp_pkg::SITE_BITS;
  localparam int CB = alp_pkg::CLR_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PROBE, S_DEL, S_DEL_END, S_SITE_RD, S_SITE_UPD
  } state_t;

  // Configuration registers.
  logic [39:0] short_lim_r, mid_lim_r, long_lim_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_lim_r <= alp_pkg::SHORT_RESET;
      mid_lim_r   <= alp_pkg::MID_RESET;
      long_lim_r  <= alp_pkg::LONG_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        alp_pkg::REG_SHORT: short_lim_r <= pwdata[39:0];
        alp_pkg::REG_MID:   mid_lim_r   <= pwdata[39:0];
        alp_pkg::REG_LONG:  long_lim_r  <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      alp_pkg::REG_SHORT: prdata = {24'd0, short_lim_r};
      alp_pkg::REG_MID:   prdata = {24'd0, mid_lim_r};
      alp_pkg::REG_LONG:  prdata = {24'd0, long_lim_r};
      default:            prdata = 64'd0;
    endcase
  end

  // Sequencer state and per-record working registers.
  state_t             state_r, state_nxt;
  logic [CB-1:0]      clr_r, clr_nxt;
  logic [1:0]         func_r, func_nxt;
  logic [59:0]        addr_r, addr_nxt;
  logic [SB-1:0]      site_r, site_nxt;
  logic [47:0]        size_r, size_nxt;
  logic [TB-1:0]      home_r, home_nxt;
  logic [TB-1:0]      idx_r, idx_nxt;      // probe position, or the scan position j
  logic [TB-1:0]      hole_r, hole_nxt;    // the slot that deletion will vacate
  logic [TB-1:0]      cnt_r, cnt_nxt;
  logic [39:0]        seq_r, seq_nxt;
  logic [SB-1:0]      sel_r, sel_nxt;      // site whose counters are read and reported
  logic [31:0]        hsize_r, hsize_nxt;
  logic [39:0]        life_r, life_nxt;
  logic [1:0]         bucket_r, bucket_nxt;
  logic [2:0]         status_r, status_nxt;

  // Registered result.
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_status_r, out_status_nxt;
  logic [SB-1:0]        out_site_r, out_site_nxt;
  logic [39:0]          out_life_r, out_life_nxt;
  alp_pkg::site_word_t  out_word_r, out_word_nxt;

  // Memory ports.
  logic                 slot_we;
  logic [TB-1:0]        slot_waddr, slot_raddr;
  alp_pkg::slot_word_t  slot_wdata, slot_rdata;
  logic                 site_we;
  logic [SB-1:0]        site_waddr;
  alp_pkg::site_word_t  site_wdata, site_rdata, site_upd;

  logic                 hash_start, hash_done;
  logic [TB-1:0]        hash_home;
  logic                 accept;
  logic [31:0]          clamped;
  logic                 cnt_last;
  logic                 shift_ok;
  logic [TB-1:0]        h;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign hash_start = accept && (in_func == alp_pkg::FN_ALLOC || in_func == alp_pkg::FN_FREE);
  assign clamped    = (size_r[47:32] != 16'd0) ? 32'hFFFF_FFFF : size_r[31:0];
  assign cnt_last   = (cnt_r == {TB{1'b1}});
  assign h          = slot_rdata.home;
  // An entry at j may fill the hole at i only if its home lies cyclically outside (i, j].
  assign shift_ok   = (hole_r < idx_r) ? (h <= hole_r || h > idx_r)
                                       : (h <= hole_r && h > idx_r);

  alp_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .addr  (in_address),
    .done  (hash_done),
    .home  (hash_home)
  );

  alp_ram #(.WIDTH($bits(alp_pkg::slot_word_t)), .DEPTH(1 << TB)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  alp_ram #(.WIDTH($bits(alp_pkg::site_word_t)), .DEPTH(1 << SB)) u_site_ram (
    .clk   (clk),
    .we    (site_we),
    .waddr (site_waddr),
    .wdata (site_wdata),
    .raddr (sel_r),
    .rdata (site_rdata)
  );

  // Counter update for the record at hand, from the site word just read.
  always_comb begin
    site_upd = site_rdata;
    if (status_r == alp_pkg::ST_ALLOC) begin
      site_upd.alloc_count = alp_pkg::sat_inc40(site_rdata.alloc_count);
      site_upd.alloc_bytes = alp_pkg::sat_add48(site_rdata.alloc_bytes, size_r);
      site_upd.live_bytes  = alp_pkg::sat_add48(site_rdata.live_bytes, {16'd0, clamped});
    end else if (status_r == alp_pkg::ST_MATCH) begin
      site_upd.free_count   = alp_pkg::sat_inc40(site_rdata.free_count);
      site_upd.lifetime_sum = alp_pkg::sat_add48(site_rdata.lifetime_sum, {8'd0, life_r});
      site_upd.bucket[bucket_r] = alp_pkg::sat_inc40(site_rdata.bucket[bucket_r]);
      site_upd.live_bytes = (site_rdata.live_bytes >= {16'd0, hsize_r})
                            ? site_rdata.live_bytes - {16'd0, hsize_r} : 48'd0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    func_nxt       = func_r;
    addr_nxt       = addr_r;
    site_nxt       = site_r;
    size_nxt       = size_r;
    home_nxt       = home_r;
    idx_nxt        = idx_r;
    hole_nxt       = hole_r;
    cnt_nxt        = cnt_r;
    seq_nxt        = seq_r;
    sel_nxt        = sel_r;
    hsize_nxt      = hsize_r;
    life_nxt       = life_r;
    bucket_nxt     = bucket_r;
    status_nxt     = status_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_site_nxt   = out_site_r;
    out_life_nxt   = out_life_r;
    out_word_nxt   = out_word_r;

    slot_we    = 1'b0;
    slot_waddr = hole_r;
    slot_wdata = slot_rdata;
    slot_raddr = idx_r;
    site_we    = 1'b0;
    site_waddr = sel_r;
    site_wdata = site_upd;

    unique case (state_r)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r[TB-1:0];
        slot_wdata = '0;
        site_we    = 1'b1;
        site_waddr = clr_r[SB-1:0];
        site_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == {CB{1'b1}}) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          func_nxt = in_func;
          addr_nxt = in_address;
          site_nxt = in_site[SB-1:0];
          size_nxt = in_size;
          sel_nxt  = in_site[SB-1:0];
          if (hash_start) begin
            state_nxt = S_HASH;
          end else begin
            status_nxt = alp_pkg::ST_READ;
            state_nxt  = S_SITE_RD;
          end
        end
      end

      S_HASH: begin
        if (hash_done) begin
          home_nxt   = hash_home;
          idx_nxt    = hash_home;
          slot_raddr = hash_home;
          cnt_nxt    = '0;
          state_nxt  = S_PROBE;
        end
      end

      S_PROBE: begin
        if (func_r == alp_pkg::FN_ALLOC) begin
          if (!slot_rdata.valid) begin
            seq_nxt          = (seq_r == {40{1'b1}}) ? seq_r : seq_r + 40'd1;
            slot_we          = 1'b1;
            slot_waddr       = idx_r;
            slot_wdata.valid = 1'b1;
            slot_wdata.home  = home_r;
            slot_wdata.addr  = addr_r;
            slot_wdata.seq   = seq_nxt;
            slot_wdata.site  = site_r;
            slot_wdata.size  = clamped;
            status_nxt       = alp_pkg::ST_ALLOC;
            state_nxt        = S_SITE_RD;
          end else if (cnt_last) begin
            status_nxt = alp_pkg::ST_FULL;
            state_nxt  = S_SITE_RD;
          end else begin
            idx_nxt    = idx_r + 1'b1;
            slot_raddr = idx_nxt;
            cnt_nxt    = cnt_r + 1'b1;
          end
        end else begin
          if (slot_rdata.valid && slot_rdata.addr == addr_r) begin
            sel_nxt    = slot_rdata.site;
            hsize_nxt  = slot_rdata.size;
            life_nxt   = (seq_r >= slot_rdata.seq) ? seq_r - slot_rdata.seq : 40'd0;
            hole_nxt   = idx_r;
            idx_nxt    = idx_r + 1'b1;
            slot_raddr = idx_nxt;
            cnt_nxt    = {{(TB-1){1'b0}}, 1'b1};
            status_nxt = alp_pkg::ST_MATCH;
            state_nxt  = S_DEL;
          end else if (!slot_rdata.valid || cnt_last) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = alp_pkg::ST_UNMATCH;
            out_site_nxt   = '0;
            out_life_nxt   = '0;
            out_word_nxt   = '0;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt    = idx_r + 1'b1;
            slot_raddr = idx_nxt;
            cnt_nxt    = cnt_r + 1'b1;
          end
        end
      end

      S_DEL: begin
        if (!slot_rdata.valid) begin
          state_nxt = S_DEL_END;
        end else begin
          if (shift_ok) begin
            slot_we    = 1'b1;
            slot_waddr = hole_r;
            slot_wdata = slot_rdata;
            hole_nxt   = idx_r;
          end
          if (cnt_last) begin
            state_nxt = S_DEL_END;
          end else begin
            idx_nxt    = idx_r + 1'b1;
            slot_raddr = idx_nxt;
            cnt_nxt    = cnt_r + 1'b1;
          end
        end
      end

      S_DEL_END: begin
        slot_we          = 1'b1;
        slot_waddr       = hole_r;
        slot_wdata       = '0;
        state_nxt        = S_SITE_RD;
      end

      S_SITE_RD: begin
        if (life_r <= short_lim_r)     bucket_nxt = 2'd0;
        else if (life_r <= mid_lim_r)  bucket_nxt = 2'd1;
        else if (life_r <= long_lim_r) bucket_nxt = 2'd2;
        else                           bucket_nxt = 2'd3;
        state_nxt = S_SITE_UPD;
      end

      S_SITE_UPD: begin
        site_we        = (status_r == alp_pkg::ST_ALLOC) || (status_r == alp_pkg::ST_MATCH);
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_site_nxt   = sel_r;
        out_life_nxt   = (status_r == alp_pkg::ST_MATCH) ? life_r : 40'd0;
        out_word_nxt   = site_upd;
        state_nxt      = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    addr_r       <= addr_nxt;
    site_r       <= site_nxt;
    size_r       <= size_nxt;
    home_r       <= home_nxt;
    idx_r        <= idx_nxt;
    hole_r       <= hole_nxt;
    cnt_r        <= cnt_nxt;
    sel_r        <= sel_nxt;
    hsize_r      <= hsize_nxt;
    life_r       <= life_nxt;
    bucket_r     <= bucket_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_site_r   <= out_site_nxt;
    out_life_r   <= out_life_nxt;
    out_word_r   <= out_word_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_site_out      = 10'(out_site_r);
  assign out_lifetime      = out_life_r;
  assign out_alloc_count   = out_word_r.alloc_count;
  assign out_alloc_bytes   = out_word_r.alloc_bytes;
  assign out_free_count    = out_word_r.free_count;
  assign out_lifetime_sum  = out_word_r.lifetime_sum;
  assign out_short_count   = out_word_r.bucket[0];
  assign out_mid_count     = out_word_r.bucket[1];
  assign out_long_count    = out_word_r.bucket[2];
  assign out_longest_count = out_word_r.bucket[3];
  assign out_live_bytes    = out_word_r.live_bytes;

  // A result ends the record's work, so no two results come back to back.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("two results in consecutive cycles");

  // A transfer always starts work that holds busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("record taken without going busy");

  // Results appear only at the end of work, never out of an idle cycle.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result without a record in flight");

  // Only a matched free reports a nonzero lifetime.
  a_life_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_lifetime != 40'd0) |-> out_status == alp_pkg::ST_MATCH)
    else $error("lifetime reported outside a matched free");

endmodule
